// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files; only cfpc_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, off during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, off during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/cfpc_pkg.sv
// Types and constants of the command frame packetizer.
package cfpc_pkg;

    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CRC_W       = 16;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8005;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;

    localparam logic [CFG_INDEX_W-1:0] REG_REGISTER_ADDRESS = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_CODE      = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHIP_ADDRESS     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ENGINE_ADDRESS   = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GENERAL_BITS     = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_FLAG       = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SEQUENCE_COUNT   = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPLETION_FLAGS = 4'd7;

    localparam logic MODE_DATA  = 1'b0;
    localparam logic MODE_CLOSE = 1'b1;

    typedef struct packed {
        logic [7:0]  register_address;
        logic [7:0]  length_code;
        logic [7:0]  chip_address;
        logic [15:0] engine_address;
        logic [6:0]  general_bits;
        logic        write_flag;
        logic [7:0]  sequence_count;
        logic [1:0]  completion_flags;
    } cfg_t;

    // One queued request: what to send and whether the header goes first.
    typedef struct packed {
        logic              mode;
        logic              with_header;
        logic [WORD_W-1:0] data_word;
    } item_t;

endpackage

// File: hw/rtl/cfpc_front.sv
// Front end: configuration registers, request intake and header tracking.
module cfpc_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cfpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cfpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic [cfpc_pkg::WORD_W-1:0]         s_data_word,
    input  logic                                q_full,
    output logic                                q_push,
    output cfpc_pkg::item_t                     q_item,
    output cfpc_pkg::cfg_t                      cfg
);
    import cfpc_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic header_sent_reg, header_sent_next;
    logic accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign q_push    = accept;
    assign cfg       = cfg_reg;

    always_comb begin
        q_item.mode        = s_mode;
        q_item.with_header = !header_sent_reg;
        q_item.data_word   = s_data_word;
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_REGISTER_ADDRESS: cfg_next.register_address = cfg_data[7:0];
                REG_LENGTH_CODE:      cfg_next.length_code      = cfg_data[7:0];
                REG_CHIP_ADDRESS:     cfg_next.chip_address     = cfg_data[7:0];
                REG_ENGINE_ADDRESS:   cfg_next.engine_address   = cfg_data[15:0];
                REG_GENERAL_BITS:     cfg_next.general_bits     = cfg_data[6:0];
                REG_WRITE_FLAG:       cfg_next.write_flag       = cfg_data[0];
                REG_SEQUENCE_COUNT:   cfg_next.sequence_count   = cfg_data[7:0];
                REG_COMPLETION_FLAGS: cfg_next.completion_flags = cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // A close ends the frame, so the next request starts a new header.
    always_comb begin
        header_sent_next = header_sent_reg;
        if (accept) begin
            header_sent_next = (s_mode == MODE_DATA);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg         <= '0;
            header_sent_reg <= 1'b0;
        end else begin
            cfg_reg         <= cfg_next;
            header_sent_reg <= header_sent_next;
        end
    end

endmodule

// File: hw/rtl/cfpc_queue.sv
// Small request queue between the front end and the byte sequencer.
module cfpc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  cfpc_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output cfpc_pkg::item_t head_item
);
    import cfpc_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    item_t           mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/cfpc_back.sv
// Back end: byte sequencer, running CRC and output register.
`include "assert_macros.svh"

module cfpc_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cfpc_pkg::cfg_t                  cfg,
    input  logic                            q_valid,
    input  cfpc_pkg::item_t                 q_head,
    output logic                            q_pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cfpc_pkg::BYTE_W-1:0]     m_frame_byte,
    output logic                            m_last_of_run,
    output logic                            m_frame_end
);
    import cfpc_pkg::*;

    typedef enum logic [11:0] {
        ST_REG_ADDR   = 12'b0000_0000_0001,
        ST_LEN_CODE   = 12'b0000_0000_0010,
        ST_CHIP_ADDR  = 12'b0000_0000_0100,
        ST_ENG_HI     = 12'b0000_0000_1000,
        ST_ENG_LO     = 12'b0000_0001_0000,
        ST_WORD_HI    = 12'b0000_0010_0000,
        ST_WORD_LO    = 12'b0000_0100_0000,
        ST_FOOT_CMD   = 12'b0000_1000_0000,
        ST_FOOT_COUNT = 12'b0001_0000_0000,
        ST_FOOT_FLAGS = 12'b0010_0000_0000,
        ST_CRC_HI     = 12'b0100_0000_0000,
        ST_CRC_LO     = 12'b1000_0000_0000
    } step_t;

    function automatic logic [CRC_W-1:0] crc_feed(logic [CRC_W-1:0] crc,
                                                  logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    step_t              step_reg, step_next, cur_step, after_step;
    logic               busy_reg, busy_next;
    logic [CRC_W-1:0]   crc_reg, crc_next;
    logic [BYTE_W-1:0]  crc_lo_reg, crc_lo_next;
    logic               m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]  m_byte_reg, m_byte_next;
    logic               m_last_reg, m_last_next;
    logic               m_end_reg, m_end_next;
    logic               out_free, emit, is_last;
    logic [BYTE_W-1:0]  cur_byte;
    logic [BYTE_W-1:0]  payload_first;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = q_valid && out_free;
    assign q_pop    = emit && is_last;

    assign payload_first = '0;

    // A fresh request starts with the header or goes straight to its body.
    always_comb begin
        if (busy_reg) begin
            cur_step = step_reg;
        end else if (q_head.with_header) begin
            cur_step = ST_REG_ADDR;
        end else if (q_head.mode == MODE_CLOSE) begin
            cur_step = ST_FOOT_CMD;
        end else begin
            cur_step = ST_WORD_HI;
        end
    end

    always_comb begin
        cur_byte   = payload_first;
        after_step = ST_REG_ADDR;
        unique case (cur_step)
            ST_REG_ADDR: begin
                cur_byte   = cfg.register_address;
                after_step = ST_LEN_CODE;
            end
            ST_LEN_CODE: begin
                cur_byte   = cfg.length_code;
                after_step = ST_CHIP_ADDR;
            end
            ST_CHIP_ADDR: begin
                cur_byte   = cfg.chip_address;
                after_step = ST_ENG_HI;
            end
            ST_ENG_HI: begin
                cur_byte   = cfg.engine_address[15:8];
                after_step = ST_ENG_LO;
            end
            ST_ENG_LO: begin
                cur_byte   = cfg.engine_address[7:0];
                after_step = (q_head.mode == MODE_CLOSE) ? ST_FOOT_CMD : ST_WORD_HI;
            end
            ST_WORD_HI: begin
                cur_byte   = q_head.data_word[15:8];
                after_step = ST_WORD_LO;
            end
            ST_WORD_LO: begin
                cur_byte   = q_head.data_word[7:0];
                after_step = ST_REG_ADDR;
            end
            ST_FOOT_CMD: begin
                cur_byte   = {cfg.general_bits, cfg.write_flag};
                after_step = ST_FOOT_COUNT;
            end
            ST_FOOT_COUNT: begin
                cur_byte   = cfg.sequence_count;
                after_step = ST_FOOT_FLAGS;
            end
            ST_FOOT_FLAGS: begin
                cur_byte   = {6'b0, cfg.completion_flags};
                after_step = ST_CRC_HI;
            end
            ST_CRC_HI: begin
                cur_byte   = crc_reg[15:8];
                after_step = ST_CRC_LO;
            end
            ST_CRC_LO: begin
                cur_byte   = crc_lo_reg;
                after_step = ST_REG_ADDR;
            end
            default: begin
                cur_byte   = payload_first;
                after_step = ST_REG_ADDR;
            end
        endcase
    end

    assign is_last = (cur_step == ST_WORD_LO) || (cur_step == ST_CRC_LO);

    always_comb begin
        step_next    = step_reg;
        busy_next    = busy_reg;
        crc_next     = crc_reg;
        crc_lo_next  = crc_lo_reg;
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        m_end_next   = m_end_reg;
        if (out_free) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
            m_byte_next  = cur_byte;
            m_last_next  = is_last;
            m_end_next   = (cur_step == ST_CRC_LO);
            busy_next    = !is_last;
            step_next    = after_step;
            crc_next     = crc_feed(crc_reg, cur_byte);
            if (cur_step == ST_CRC_HI) begin
                // low byte must be the pre-feed value
                crc_lo_next = crc_reg[7:0];
            end
            if (cur_step == ST_CRC_LO) begin
                crc_next = CRC_INIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        m_end_reg  <= m_end_next;
        crc_lo_reg <= crc_lo_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= ST_REG_ADDR;
            busy_reg    <= 1'b0;
            crc_reg     <= CRC_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            busy_reg    <= busy_next;
            crc_reg     <= crc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_frame_byte  = m_byte_reg;
    assign m_last_of_run = m_last_reg;
    assign m_frame_end   = m_end_reg;

    `ASSERT_IMP(a_end_is_last, aclk, aresetn, m_valid_reg && m_end_reg, m_last_reg)
    `ASSERT_IMP(a_busy_has_item, aclk, aresetn, busy_reg, q_valid)
    `ASSERT_IMP(a_pop_on_last, aclk, aresetn, q_pop, emit && is_last)
    `ASSERT_NXT(a_crc_cleared, aclk, aresetn, emit && (cur_step == ST_CRC_LO), crc_reg == CRC_INIT)

endmodule

// File: hw/rtl/command_frame_packetizer_crc16.sv
// Top level of the command frame packetizer with CRC-16.
//
//  channel | ports                               | direction | moves
//  --------+-------------------------------------+-----------+----------------------
//  cfg     | cfg_valid/ready, cfg_index/data     | in        | register write
//  s       | s_valid/ready, s_mode, s_data_word  | in        | data or close request
//  m       | m_valid/ready, m_frame_byte, flags  | out       | one frame byte
//
// One byte leaves per cycle unless m stalls or the queue is empty. A data request
// sends its word high byte first, a close the footer and the CRC; the header goes
// first when it carries one. Bytes pass the queue and then the output register.
// Synchronous active-low reset clears the queue, header flag, CRC and registers.
// A stalled m channel holds its byte; the queue keeps taking requests until full.
module command_frame_packetizer_crc16 #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cfpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cfpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic [cfpc_pkg::WORD_W-1:0]         s_data_word,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [cfpc_pkg::BYTE_W-1:0]         m_frame_byte,
    output logic                                m_last_of_run,
    output logic                                m_frame_end
);
    import cfpc_pkg::*;

    cfg_t  cfg;
    item_t push_item;
    item_t head_item;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;

    cfpc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_data_word (s_data_word),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item),
        .cfg         (cfg)
    );

    cfpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    cfpc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_head        (head_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_frame_byte  (m_frame_byte),
        .m_last_of_run (m_last_of_run),
        .m_frame_end   (m_frame_end)
    );

endmodule
